FILE: rtl/core/text_console_renderer_assert.svh
// Assertion macros for the console renderer checker
`ifndef TEXT_CONSOLE_RENDERER_ASSERT_SVH
`define TEXT_CONSOLE_RENDERER_ASSERT_SVH

// Same-cycle implication under the block reset
`define TCR_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcr assertion failed");

// Next-cycle implication under the block reset
`define TCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcr assertion failed");

`endif

FILE: rtl/core/tcr_pkg.sv
// Shared constants and codes for the text console renderer
package tcr_pkg;

    // Field widths
    localparam int OP_W     = 1;
    localparam int CHAR_W   = 8;
    localparam int FADDR_W  = 11;
    localparam int FBYTE_W  = 8;
    localparam int COORD_W  = 12;
    localparam int YSUM_W   = COORD_W + 2;
    localparam int GLYPH_COLS = 8;

    // Parameter defaults
    localparam int GLYPH_ROWS_DEF  = 16;
    localparam int GLYPH_COUNT_DEF = 95;

    // APB port
    localparam int APB_DW  = 32;
    localparam int PADDR_W = 3;

    // Register indexes (paddr[2])
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Register reset values
    localparam logic [COORD_W-1:0] WIDTH_RST  = 12'd640;
    localparam logic [COORD_W-1:0] HEIGHT_RST = 12'd480;

    // Opcodes
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Result kinds
    localparam logic KIND_ROW    = 1'b0;
    localparam logic KIND_SCROLL = 1'b1;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CHAR_NL    = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_FIRST = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_LAST  = 8'd126;

    // Scroll amount ceiling
    localparam int LINES_MAX = 4095;

endpackage

FILE: rtl/core/tcr_if.sv
// Stream interfaces for the renderer command and result channels

// Command channel: put character or font load
interface tcr_cmd_if import tcr_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    opcode;
    logic [CHAR_W-1:0]  char_code;
    logic [FADDR_W-1:0] font_address;
    logic [FBYTE_W-1:0] font_byte;

    modport source (output valid, opcode, char_code, font_address, font_byte, input ready);
    modport sink   (input valid, opcode, char_code, font_address, font_byte, output ready);
endinterface

// Result channel: glyph row writes and scroll commands
interface tcr_res_if import tcr_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [7:0]         glyph_bits;
    logic [7:0]         write_mask;
    logic [COORD_W-1:0] scroll_lines;
    logic               last;

    modport source (output valid, kind, pixel_x, pixel_y, glyph_bits, write_mask,
                    scroll_lines, last, input ready);
    modport sink   (input valid, kind, pixel_x, pixel_y, glyph_bits, write_mask,
                    scroll_lines, last, output ready);
endinterface

FILE: rtl/core/text_console_renderer.sv
// Text console renderer top level: cursor control, font memory and result pipeline
//
// A put-character beat is decoded in the cycle after it is taken, which also updates
// the cursor. A printable character or a backspace then streams one glyph row per
// cycle while the result stages are free, up to GLYPH_ROWS rows and no further than
// the screen bottom, out of the single-port-read font memory, followed by a scroll
// command when the cursor passes the bottom. The next command beat is taken once the
// last row or scroll has been issued; the font memory read port sets the row rate.
// A font load beat writes the font memory as it is taken. Results pass through a
// read-data stage and an output register, so one more row is read while a result
// waits; after that the rows stall until it is taken.
// The font memory has no reset: rows must be loaded before they are drawn.
module text_console_renderer import tcr_pkg::*;
#(
    parameter int GLYPH_ROWS  = GLYPH_ROWS_DEF,
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    tcr_cmd_if.sink            cmd,
    tcr_res_if.source          res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    localparam int FONT_SIZE = GLYPH_COUNT * GLYPH_ROWS;
    localparam int FONT_AW   = $clog2(FONT_SIZE);
    localparam int GIDX_W    = $clog2(GLYPH_COUNT);
    localparam int ROW_CW    = $clog2(GLYPH_ROWS + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CALC   = 4'b0010,
        ST_ROWS   = 4'b0100,
        ST_SCROLL = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Configuration and cursor
    logic [COORD_W-1:0] width_reg, height_reg;
    logic [COORD_W-1:0] cursor_x_reg, cursor_y_reg;

    // Per-character working registers
    logic [CHAR_W-1:0]  code_reg;
    logic               scroll_reg;
    logic [COORD_W-1:0] lines_reg;
    logic [COORD_W-1:0] cur_x_reg;
    logic [7:0]         cur_mask_reg;
    logic [FONT_AW-1:0] addr_reg;
    logic [COORD_W-1:0] row_y_reg;
    logic [ROW_CW-1:0]  rows_left_reg;

    // Read-data stage
    logic               s1_valid_reg;
    logic               s1_kind_reg;
    logic [COORD_W-1:0] s1_x_reg, s1_y_reg, s1_lines_reg;
    logic [7:0]         s1_mask_reg;
    logic               s1_last_reg;
    logic [7:0]         rd_data_reg;

    // Output register
    logic               res_valid_reg;
    logic               res_kind_reg;
    logic [COORD_W-1:0] res_x_reg, res_y_reg, res_lines_reg;
    logic [7:0]         res_bits_reg, res_mask_reg;
    logic               res_last_reg;

    logic [7:0] font_mem [FONT_SIZE];

    // Command and configuration handshakes
    logic cmd_fire, cfg_wr, mem_we;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign mem_we    = cmd_fire && (cmd.opcode == OP_LOAD)
                       && (int'(cmd.font_address) < FONT_SIZE);
    assign cfg_wr    = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_HEIGHT) ? {{(APB_DW-COORD_W){1'b0}}, height_reg}
                                                : {{(APB_DW-COORD_W){1'b0}}, width_reg};

    // Character decode and cursor update
    logic               is_nl, is_bs, printable, draw, rows_go;
    logic [COORD_W-1:0] x_bs, draw_x, x_new, y_new, y_hold, lines_sat;
    logic [COORD_W:0]   x_adv;
    logic               wrap, scroll;
    logic [YSUM_W-1:0]  y_a, y_b, y_end, h_ext, lines_full;
    logic [GIDX_W-1:0]  gidx;
    logic [FONT_AW-1:0] base_addr;
    logic [7:0]         mask;

    always_comb
    begin
        is_nl     = (code_reg == CHAR_NL);
        is_bs     = (code_reg == CHAR_BS);
        printable = (code_reg >= CHAR_FIRST) && (code_reg <= CHAR_LAST);
        draw      = is_bs || printable;
        x_bs      = (cursor_x_reg < COORD_W'(GLYPH_COLS)) ? '0
                    : cursor_x_reg - COORD_W'(GLYPH_COLS);
        draw_x    = is_bs ? x_bs : cursor_x_reg;
        if (is_nl)
            x_adv = '0;
        else if (is_bs)
            x_adv = {1'b0, x_bs};
        else
            x_adv = {1'b0, cursor_x_reg} + (COORD_W+1)'(GLYPH_COLS);
        wrap       = x_adv >= {1'b0, width_reg};
        x_new      = wrap ? '0 : x_adv[COORD_W-1:0];
        y_a        = {2'b00, cursor_y_reg} + (is_nl ? YSUM_W'(GLYPH_ROWS) : '0);
        y_b        = y_a + (wrap ? YSUM_W'(GLYPH_ROWS) : '0);
        y_end      = y_b + YSUM_W'(GLYPH_ROWS);
        h_ext      = {2'b00, height_reg};
        scroll     = y_end > h_ext;
        lines_full = y_end - h_ext;
        lines_sat  = (lines_full > YSUM_W'(LINES_MAX)) ? COORD_W'(LINES_MAX)
                     : lines_full[COORD_W-1:0];
        y_hold     = (height_reg >= COORD_W'(GLYPH_ROWS)) ?
                     height_reg - COORD_W'(GLYPH_ROWS) : '0;
        y_new      = scroll ? y_hold : y_b[COORD_W-1:0];
        gidx       = is_bs ? '0 : GIDX_W'(code_reg - CHAR_FIRST);
        base_addr  = FONT_AW'(int'(gidx) * GLYPH_ROWS);
        rows_go    = draw && (cursor_y_reg < height_reg);
        // Clip columns at the screen width
        for (int j = 0; j < GLYPH_COLS; j++)
        begin
            mask[GLYPH_COLS-1-j] = ({1'b0, draw_x} + (COORD_W+1)'(j)) < {1'b0, width_reg};
        end
    end

    // Row issue control
    logic out_free, s1_free, row_issue, scroll_issue, row_done, issue;
    assign out_free     = !res_valid_reg || res.ready;
    assign s1_free      = !s1_valid_reg || out_free;
    assign row_issue    = (state_reg == ST_ROWS) && s1_free;
    assign scroll_issue = (state_reg == ST_SCROLL) && s1_free;
    assign issue        = row_issue || scroll_issue;
    assign row_done     = (rows_left_reg == ROW_CW'(1))
                          || (({1'b0, row_y_reg} + (COORD_W+1)'(1)) >= {1'b0, height_reg});

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire && (cmd.opcode == OP_PUT))
                    state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (rows_go)
                    state_next = ST_ROWS;
                else if (scroll)
                    state_next = ST_SCROLL;
                else
                    state_next = ST_IDLE;
            end
            ST_ROWS:
            begin
                if (row_issue && row_done)
                    state_next = scroll_reg ? ST_SCROLL : ST_IDLE;
            end
            ST_SCROLL:
            begin
                if (scroll_issue)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= WIDTH_RST;
            height_reg    <= HEIGHT_RST;
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr && (paddr[2] == REG_WIDTH))
                width_reg <= pwdata[COORD_W-1:0];
            if (cfg_wr && (paddr[2] == REG_HEIGHT))
                height_reg <= pwdata[COORD_W-1:0];
            if (state_reg == ST_CALC)
            begin
                cursor_x_reg <= x_new;
                cursor_y_reg <= y_new;
            end
            if (issue)
                s1_valid_reg <= 1'b1;
            else if (out_free)
                s1_valid_reg <= 1'b0;
            if (out_free)
                res_valid_reg <= s1_valid_reg;
        end
    end

    // Working registers and result payload
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
            code_reg <= cmd.char_code;
        if (state_reg == ST_CALC)
        begin
            scroll_reg    <= scroll;
            lines_reg     <= lines_sat;
            cur_x_reg     <= draw_x;
            cur_mask_reg  <= mask;
            addr_reg      <= base_addr;
            row_y_reg     <= cursor_y_reg;
            rows_left_reg <= ROW_CW'(GLYPH_ROWS);
        end
        else if (row_issue)
        begin
            addr_reg      <= addr_reg + FONT_AW'(1);
            row_y_reg     <= row_y_reg + COORD_W'(1);
            rows_left_reg <= rows_left_reg - ROW_CW'(1);
        end
        // Read-data stage beat
        if (row_issue)
        begin
            s1_kind_reg  <= KIND_ROW;
            s1_x_reg     <= cur_x_reg;
            s1_y_reg     <= row_y_reg;
            s1_mask_reg  <= cur_mask_reg;
            s1_lines_reg <= '0;
            s1_last_reg  <= row_done && !scroll_reg;
        end
        else if (scroll_issue)
        begin
            s1_kind_reg  <= KIND_SCROLL;
            s1_x_reg     <= '0;
            s1_y_reg     <= '0;
            s1_mask_reg  <= '0;
            s1_lines_reg <= lines_reg;
            s1_last_reg  <= 1'b1;
        end
        // Output beat
        if (out_free && s1_valid_reg)
        begin
            res_kind_reg  <= s1_kind_reg;
            res_x_reg     <= s1_x_reg;
            res_y_reg     <= s1_y_reg;
            res_bits_reg  <= (s1_kind_reg == KIND_ROW) ? rd_data_reg : '0;
            res_mask_reg  <= s1_mask_reg;
            res_lines_reg <= s1_lines_reg;
            res_last_reg  <= s1_last_reg;
        end
    end

    // Font memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            font_mem[FONT_AW'(cmd.font_address)] <= cmd.font_byte;
        if (row_issue)
            rd_data_reg <= font_mem[addr_reg];
    end

    assign res.valid        = res_valid_reg;
    assign res.kind         = res_kind_reg;
    assign res.pixel_x      = res_x_reg;
    assign res.pixel_y      = res_y_reg;
    assign res.glyph_bits   = res_bits_reg;
    assign res.write_mask   = res_mask_reg;
    assign res.scroll_lines = res_lines_reg;
    assign res.last         = res_last_reg;

endmodule

FILE: rtl/core/tcr_checker.sv
// Port-level checker for the text console renderer result channel, with its bind
`include "text_console_renderer_assert.svh"

module tcr_checker import tcr_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_ready,
    input logic               kind,
    input logic [COORD_W-1:0] pixel_x,
    input logic [COORD_W-1:0] pixel_y,
    input logic [7:0]         glyph_bits,
    input logic [7:0]         write_mask,
    input logic [COORD_W-1:0] scroll_lines,
    input logic               last
);

    // Scroll beat closes its command and carries only the scroll amount
    `TCR_ASSERT(a_scroll_beat, clk, rst_n, res_valid && (kind == KIND_SCROLL), last && (scroll_lines != '0) && (pixel_x == '0) && (pixel_y == '0) && (glyph_bits == '0) && (write_mask == '0))

    // Row beat has no scroll amount and a left-aligned clip mask
    `TCR_ASSERT(a_row_beat, clk, rst_n, res_valid && (kind == KIND_ROW), (scroll_lines == '0) && ((((~write_mask) + 8'd1) & (~write_mask)) == 8'd0))

    // A stalled beat holds
    `TCR_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(kind) && $stable(pixel_x) && $stable(pixel_y) && $stable(glyph_bits) && $stable(write_mask) && $stable(scroll_lines) && $stable(last))

endmodule

bind text_console_renderer tcr_checker u_tcr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .kind         (res.kind),
    .pixel_x      (res.pixel_x),
    .pixel_y      (res.pixel_y),
    .glyph_bits   (res.glyph_bits),
    .write_mask   (res.write_mask),
    .scroll_lines (res.scroll_lines),
    .last         (res.last)
);
